### hdl/mfb_pkg.sv
// Shared types, constants and helper functions of the framebuffer draw engine.
package mfb_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int FB_BYTES      = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
    localparam int AW            = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam int XW            = $clog2(SCREEN_WIDTH);
    localparam int YW            = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int CW            = 13;

    typedef enum logic [2:0] {
        FN_PIXEL     = 3'd0,
        FN_HLINE     = 3'd1,
        FN_VLINE     = 3'd2,
        FN_RECT      = 3'd3,
        FN_CLEAR     = 3'd4,
        FN_IMG_START = 3'd5,
        FN_IMG_BYTE  = 3'd6,
        FN_READ      = 3'd7
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [9:0]  span_width;
        logic [9:0]  span_height;
        logic [9:0]  line_length;
        logic        color;
        logic        fill;
        logic [7:0]  image_data;
        logic [9:0]  byte_address;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       image_finished;
        logic       byte_ignored;
    } res_t;

    typedef enum logic [2:0] {
        JOB_DRAW  = 3'd0,
        JOB_CLEAR = 3'd1,
        JOB_START = 3'd2,
        JOB_BYTE  = 3'd3,
        JOB_READ  = 3'd4
    } job_kind_t;

    typedef struct packed {
        logic [XW-1:0] x0;
        logic [XW-1:0] x1;
        logic [YW-1:0] y0;
        logic [YW-1:0] y1;
    } box_t;

    typedef struct packed {
        job_kind_t      kind;
        logic           color;
        logic [2:0]     nbox;
        box_t [3:0]     boxes;
        logic [11:0]    x_pos;
        logic [11:0]    y_pos;
        logic [9:0]     span_width;
        logic [9:0]     span_height;
        logic [15:0]    count;
        logic [7:0]     image_data;
        logic [9:0]     byte_address;
    } job_t;

    function automatic logic [XW-1:0] clamp_x(input logic [CW-1:0] v);
        return (v >= CW'(SCREEN_WIDTH)) ? XW'(SCREEN_WIDTH - 1) : v[XW-1:0];
    endfunction

    function automatic logic [YW-1:0] clamp_y(input logic [CW-1:0] v);
        return (v >= CW'(SCREEN_HEIGHT)) ? YW'(SCREEN_HEIGHT - 1) : v[YW-1:0];
    endfunction

    function automatic box_t make_box(input logic [CW-1:0] x0, input logic [CW-1:0] x1,
                                      input logic [CW-1:0] y0, input logic [CW-1:0] y1);
        box_t b;
        b.x0 = clamp_x(x0);
        b.x1 = clamp_x(x1);
        b.y0 = clamp_y(y0);
        b.y1 = clamp_y(y1);
        return b;
    endfunction

    // The store is kept upside down and mirrored: row 0 sits at the end.
    function automatic logic [AW:0] pix_byte(input logic [XW-1:0] cx, input logic [YW-1:0] cy);
        int lin;
        lin = SCREEN_WIDTH * (SCREEN_HEIGHT - 1 - int'(cy)) + (SCREEN_WIDTH - 1 - int'(cx));
        return (AW + 1)'(lin >> 3);
    endfunction

    function automatic logic [7:0] pix_mask(input logic [XW-1:0] cx);
        return 8'h80 >> cx[2:0];
    endfunction

endpackage

### hdl/mfb_front.sv
// Front end: accepts requests and turns each into a job, with clamped boxes for drawing requests.
module mfb_front (
    input  logic              req_valid,
    output logic              req_stall,
    input  mfb_pkg::req_t     req,
    input  logic              queue_full,
    input  logic              init_busy,
    output logic              push,
    output mfb_pkg::job_t     job
);

    logic [mfb_pkg::CW-1:0] x13, y13, w13, h13, len13;
    logic [19:0]            area;

    assign req_stall = queue_full | init_busy;
    assign push      = req_valid & ~req_stall;

    always_comb
    begin
        x13   = {1'b0, req.x_pos};
        y13   = {1'b0, req.y_pos};
        w13   = {3'b0, req.span_width};
        h13   = {3'b0, req.span_height};
        len13 = {3'b0, req.line_length};
        area  = 20'(req.span_width) * 20'(req.span_height);

        job              = '0;
        job.kind         = mfb_pkg::JOB_DRAW;
        job.color        = req.color;
        job.x_pos        = req.x_pos;
        job.y_pos        = req.y_pos;
        job.span_width   = req.span_width;
        job.span_height  = req.span_height;
        job.count        = area[18:3];
        job.image_data   = req.image_data;
        job.byte_address = req.byte_address;

        unique case (req.func)
            mfb_pkg::FN_PIXEL:
            begin
                job.nbox     = 3'd1;
                job.boxes[0] = mfb_pkg::make_box(x13, x13, y13, y13);
            end
            mfb_pkg::FN_HLINE:
            begin
                job.nbox     = 3'd1;
                job.boxes[0] = mfb_pkg::make_box(x13, x13 + len13, y13, y13);
            end
            mfb_pkg::FN_VLINE:
            begin
                job.nbox     = 3'd1;
                job.boxes[0] = mfb_pkg::make_box(x13, x13, y13, y13 + len13);
            end
            mfb_pkg::FN_RECT:
            begin
                if (req.fill)
                begin
                    if (req.span_width != 10'd0 && req.span_height != 10'd0)
                    begin
                        job.nbox     = 3'd1;
                        job.boxes[0] = mfb_pkg::make_box(x13, x13 + w13 - 13'd1,
                                                         y13, y13 + h13 - 13'd1);
                    end
                end
                else
                begin
                    job.nbox     = 3'd4;
                    job.boxes[0] = mfb_pkg::make_box(x13, x13 + w13, y13, y13);
                    job.boxes[1] = mfb_pkg::make_box(x13, x13 + w13, y13 + h13, y13 + h13);
                    job.boxes[2] = mfb_pkg::make_box(x13, x13, y13, y13 + h13);
                    job.boxes[3] = mfb_pkg::make_box(x13 + w13, x13 + w13, y13, y13 + h13);
                end
            end
            mfb_pkg::FN_CLEAR:     job.kind = mfb_pkg::JOB_CLEAR;
            mfb_pkg::FN_IMG_START: job.kind = mfb_pkg::JOB_START;
            mfb_pkg::FN_IMG_BYTE:  job.kind = mfb_pkg::JOB_BYTE;
            mfb_pkg::FN_READ:      job.kind = mfb_pkg::JOB_READ;
        endcase
    end

endmodule

### hdl/mfb_queue.sv
// Two-entry job queue between the front end and the drawing back end.
module mfb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mfb_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output mfb_pkg::job_t head
);

    mfb_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

### hdl/mfb_back.sv
// Back end: walks jobs pixel by pixel over the frame store and issues results.
module mfb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  mfb_pkg::job_t job_in,
    output logic          pop,
    output logic          init_busy,
    output logic          res_valid,
    input  logic          res_stall,
    output mfb_pkg::res_t res
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_BOX_RD,
        S_BOX_WR,
        S_BIT_RD,
        S_BIT_WR,
        S_READ_RD,
        S_READ_DATA,
        S_RESULT
    } state_t;

    state_t                 state_reg;
    mfb_pkg::job_t          job_reg;
    mfb_pkg::res_t          pend_reg;
    mfb_pkg::res_t          out_reg;
    logic                   out_valid_reg;
    logic [mfb_pkg::AW-1:0] clr_addr_reg;
    logic [7:0]             clr_val_reg;
    logic [1:0]             box_idx_reg;
    logic [mfb_pkg::XW-1:0] px_reg;
    logic [mfb_pkg::YW-1:0] py_reg;

    logic                   active_reg;
    logic [11:0]            sx_reg;
    logic [11:0]            sy_reg;
    logic [mfb_pkg::CW-1:0] cur_x_reg;
    logic [mfb_pkg::CW-1:0] cur_y_reg;
    logic [9:0]             bw_reg;
    logic [9:0]             bh_reg;
    logic [15:0]            left_reg;
    logic [2:0]             bit_reg;
    logic [7:0]             data_reg;

    logic [7:0]             mem [mfb_pkg::FB_BYTES];
    logic [7:0]             mem_q;
    logic                   mem_we;
    logic [mfb_pkg::AW-1:0] mem_waddr;
    logic [mfb_pkg::AW-1:0] mem_raddr;
    logic [7:0]             mem_wdata;

    mfb_pkg::box_t          cur_box;
    logic [mfb_pkg::XW-1:0] cx;
    logic [mfb_pkg::YW-1:0] cy;
    logic [mfb_pkg::AW:0]   pix;
    logic                   pix_ok;
    logic [7:0]             mask;
    logic                   pen;
    logic [mfb_pkg::CW-1:0] nx;
    logic [mfb_pkg::CW-1:0] ny;
    logic                   wrap;
    logic                   geo_done;
    logic [15:0]            left_dec;

    assign init_busy = (state_reg == S_INIT);
    assign pop       = (state_reg == S_IDLE) && job_valid;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign cur_box   = job_reg.boxes[box_idx_reg];

    always_comb
    begin
        if (state_reg == S_BIT_RD || state_reg == S_BIT_WR)
        begin
            cx  = mfb_pkg::clamp_x(cur_x_reg);
            cy  = mfb_pkg::clamp_y(cur_y_reg);
            pen = data_reg[7];
        end
        else
        begin
            cx  = px_reg;
            cy  = py_reg;
            pen = job_reg.color;
        end
        pix    = mfb_pkg::pix_byte(cx, cy);
        pix_ok = 32'(pix) < 32'(mfb_pkg::FB_BYTES);
        mask   = mfb_pkg::pix_mask(cx);

        nx       = cur_x_reg + 13'd1;
        wrap     = (nx - {1'b0, sx_reg}) == {3'b0, bw_reg};
        ny       = wrap ? cur_y_reg + 13'd1 : cur_y_reg;
        geo_done = ((ny - {1'b0, sy_reg}) == {3'b0, bh_reg}) ||
                   (ny >= mfb_pkg::CW'(mfb_pkg::SCREEN_HEIGHT));
        left_dec = left_reg - 16'd1;

        mem_we    = 1'b0;
        mem_waddr = pix[mfb_pkg::AW-1:0];
        mem_wdata = pen ? (mem_q & ~mask) : (mem_q | mask);
        mem_raddr = pix[mfb_pkg::AW-1:0];
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = clr_val_reg;
            end
            S_BOX_WR, S_BIT_WR: mem_we = pix_ok;
            S_READ_RD:          mem_raddr = mfb_pkg::AW'(job_reg.byte_address);
            default:            mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            job_reg       <= '0;
            pend_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            clr_val_reg   <= 8'h00;
            box_idx_reg   <= 2'd0;
            px_reg        <= '0;
            py_reg        <= '0;
            active_reg    <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            bw_reg        <= '0;
            bh_reg        <= '0;
            left_reg      <= '0;
            bit_reg       <= '0;
            data_reg      <= '0;
        end
        else
        begin
            if (state_reg == S_RESULT && (!out_valid_reg || !res_stall))
            begin
                out_reg       <= pend_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !res_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_INIT, S_CLEAR:
                begin
                    if (clr_addr_reg == mfb_pkg::AW'(mfb_pkg::FB_BYTES - 1))
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= (state_reg == S_INIT) ? S_IDLE : S_RESULT;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg     <= job_in;
                        box_idx_reg <= 2'd0;
                        px_reg      <= job_in.boxes[0].x0;
                        py_reg      <= job_in.boxes[0].y0;
                        unique case (job_in.kind)
                            mfb_pkg::JOB_DRAW:
                            begin
                                pend_reg  <= '0;
                                state_reg <= (job_in.nbox != 3'd0) ? S_BOX_RD : S_RESULT;
                            end
                            mfb_pkg::JOB_CLEAR:
                            begin
                                pend_reg    <= '0;
                                clr_val_reg <= job_in.color ? 8'h00 : 8'hFF;
                                state_reg   <= S_CLEAR;
                            end
                            mfb_pkg::JOB_START:
                            begin
                                pend_reg   <= '0;
                                sx_reg     <= job_in.x_pos;
                                sy_reg     <= job_in.y_pos;
                                cur_x_reg  <= {1'b0, job_in.x_pos};
                                cur_y_reg  <= {1'b0, job_in.y_pos};
                                bw_reg     <= job_in.span_width;
                                bh_reg     <= job_in.span_height;
                                left_reg   <= job_in.count;
                                active_reg <= (job_in.count != 16'd0);
                                state_reg  <= S_RESULT;
                            end
                            mfb_pkg::JOB_BYTE:
                            begin
                                if (!active_reg)
                                begin
                                    pend_reg  <= mfb_pkg::res_t'{read_data: 8'h00,
                                                                 image_finished: 1'b0,
                                                                 byte_ignored: 1'b1};
                                    state_reg <= S_RESULT;
                                end
                                else
                                begin
                                    pend_reg  <= '0;
                                    bit_reg   <= 3'd0;
                                    data_reg  <= job_in.image_data;
                                    state_reg <= S_BIT_RD;
                                end
                            end
                            mfb_pkg::JOB_READ:
                            begin
                                pend_reg <= '0;
                                if (32'(job_in.byte_address) < 32'(mfb_pkg::FB_BYTES))
                                begin
                                    state_reg <= S_READ_RD;
                                end
                                else
                                begin
                                    state_reg <= S_RESULT;
                                end
                            end
                            default:
                            begin
                                pend_reg  <= '0;
                                state_reg <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_BOX_RD: state_reg <= S_BOX_WR;
                S_BOX_WR:
                begin
                    if (px_reg != cur_box.x1)
                    begin
                        px_reg    <= px_reg + 1'b1;
                        state_reg <= S_BOX_RD;
                    end
                    else if (py_reg != cur_box.y1)
                    begin
                        px_reg    <= cur_box.x0;
                        py_reg    <= py_reg + 1'b1;
                        state_reg <= S_BOX_RD;
                    end
                    else if (3'(box_idx_reg) + 3'd1 < job_reg.nbox)
                    begin
                        box_idx_reg <= box_idx_reg + 2'd1;
                        px_reg      <= job_reg.boxes[box_idx_reg + 2'd1].x0;
                        py_reg      <= job_reg.boxes[box_idx_reg + 2'd1].y0;
                        state_reg   <= S_BOX_RD;
                    end
                    else
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_BIT_RD: state_reg <= S_BIT_WR;
                S_BIT_WR:
                begin
                    cur_x_reg <= wrap ? {1'b0, sx_reg} : nx;
                    cur_y_reg <= ny;
                    data_reg  <= {data_reg[6:0], 1'b0};
                    bit_reg   <= bit_reg + 3'd1;
                    // The blit may end part way through a byte.
                    if (geo_done)
                    begin
                        active_reg              <= 1'b0;
                        pend_reg.image_finished <= 1'b1;
                        state_reg               <= S_RESULT;
                    end
                    else if (bit_reg == 3'd7)
                    begin
                        left_reg  <= left_dec;
                        state_reg <= S_RESULT;
                        if (left_dec == 16'd0)
                        begin
                            active_reg              <= 1'b0;
                            pend_reg.image_finished <= 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_BIT_RD;
                    end
                end
                S_READ_RD: state_reg <= S_READ_DATA;
                S_READ_DATA:
                begin
                    pend_reg.read_data <= mem_q;
                    state_reg          <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (!out_valid_reg || !res_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/mono_framebuffer_draw_engine_unit.sv
// Top level of the monochrome framebuffer draw engine.
//
// Requests arrive on req (req_valid / req_stall) and each gives exactly one
// result on res (res_valid / res_stall), in request order. A request is taken
// at a clock edge where its valid is high and its stall is low.
// The front end decodes a request into a job of up to four clamped boxes and
// places it in a two-entry queue; the back end carries jobs out against the
// frame store, one read-modify-write per pixel; a clear writes all 1024 store
// bytes with the default screen. The result register lets the back end finish
// one more job while the receiver stalls; the queue keeps accepting until both
// entries are full. After reset the frame store is swept to zero, one byte a
// cycle, and req_stall stays high until that pass is over.
module mono_framebuffer_draw_engine_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  mfb_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_stall,
    output mfb_pkg::res_t res
);

    mfb_pkg::job_t front_job;
    mfb_pkg::job_t head_job;
    logic          push;
    logic          pop;
    logic          queue_full;
    logic          queue_not_empty;
    logic          init_busy;

    mfb_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .push       (push),
        .job        (front_job)
    );

    mfb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (front_job),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_job)
    );

    mfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job_in    (head_job),
        .pop       (pop),
        .init_busy (init_busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
